// ----- src/divs_pkg.sv -----
// Package for the pipelined 64-bit signed/unsigned divider.
// Holds the word-size constants and the control struct carried down the pipeline.
// No dependencies.
package divs_pkg;

  localparam int DIVS_WORD_BITS  = 64;
  localparam int DIVS_FIELD_BITS = 64;

  localparam logic DIVS_OP_UNSIGNED = 1'b0;
  localparam logic DIVS_OP_SIGNED   = 1'b1;

  typedef struct packed {
    logic neg_q;
    logic neg_r;
    logic dz;
  } divs_ctl_t;

endpackage

// ----- src/divs_if.sv -----
// Valid/ready channel interfaces for the divider's operand and result transactions.
// Depends on divs_pkg for the field widths.
interface divs_in_if
  import divs_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [DIVS_FIELD_BITS-1:0] dividend;
  logic [DIVS_FIELD_BITS-1:0] divisor;

  modport source (output valid, output op, output dividend, output divisor, input ready);
  modport sink   (input valid, input op, input dividend, input divisor, output ready);
endinterface

interface divs_out_if
  import divs_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [DIVS_FIELD_BITS-1:0] quotient;
  logic [DIVS_FIELD_BITS-1:0] remainder;
  logic                       div_by_zero;

  modport source (output valid, output quotient, output remainder, output div_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input div_by_zero,
                  output ready);
endinterface

// ----- src/divs_pre.sv -----
// Entry stage: truncates operands to the word size, takes magnitudes in signed mode
// and flags a zero divisor. Depends on divs_pkg.
module divs_pre
  import divs_pkg::*;
#(
  parameter int W = DIVS_WORD_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       valid_i,
  input  logic                       op_i,
  input  logic [DIVS_FIELD_BITS-1:0] dividend_i,
  input  logic [DIVS_FIELD_BITS-1:0] divisor_i,
  output logic                       valid_o,
  output logic [W-1:0]               n_o,
  output logic [W-1:0]               d_o,
  output divs_ctl_t                  ctl_o
);

  logic            valid_r;
  logic [W-1:0]    n_r, d_r;
  divs_ctl_t       ctl_r;
  logic [W-1:0]    a, b, n_nxt, d_nxt;
  logic            neg_a, neg_b;
  divs_ctl_t       ctl_nxt;

  always_comb begin
    a     = dividend_i[W-1:0];
    b     = divisor_i[W-1:0];
    neg_a = (op_i == DIVS_OP_SIGNED) && a[W-1];
    neg_b = (op_i == DIVS_OP_SIGNED) && b[W-1];
    n_nxt = neg_a ? W'(~a + 1'b1) : a;
    d_nxt = neg_b ? W'(~b + 1'b1) : b;
    ctl_nxt.neg_q = neg_a ^ neg_b;
    ctl_nxt.neg_r = neg_a;
    ctl_nxt.dz    = (b == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r   <= n_nxt;
      d_r   <= d_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  assign valid_o = valid_r;
  assign n_o     = n_r;
  assign d_o     = d_r;
  assign ctl_o   = ctl_r;

endmodule

// ----- src/divs_step.sv -----
// One restoring shift-subtract step of the divider pipeline, with its stage register.
// The dividend shifts out of the top of nq while quotient bits shift in at the bottom.
// Depends on divs_pkg.
module divs_step
  import divs_pkg::*;
#(
  parameter int W = DIVS_WORD_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         valid_i,
  input  logic [W-1:0] r_i,
  input  logic [W-1:0] nq_i,
  input  logic [W-1:0] d_i,
  input  divs_ctl_t    ctl_i,
  output logic         valid_o,
  output logic [W-1:0] r_o,
  output logic [W-1:0] nq_o,
  output logic [W-1:0] d_o,
  output divs_ctl_t    ctl_o
);

  logic         valid_r;
  logic [W-1:0] r_r, nq_r, d_r;
  divs_ctl_t    ctl_r;
  logic [W:0]   rs, diff;
  logic         ge;
  logic [W-1:0] r_nxt, nq_nxt;

  always_comb begin
    rs     = {r_i, nq_i[W-1]};
    ge     = (rs >= {1'b0, d_i});
    diff   = rs - {1'b0, d_i};
    r_nxt  = ge ? diff[W-1:0] : rs[W-1:0];
    nq_nxt = {nq_i[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r   <= r_nxt;
      nq_r  <= nq_nxt;
      d_r   <= d_i;
      ctl_r <= ctl_i;
    end
  end

  assign valid_o = valid_r;
  assign r_o     = r_r;
  assign nq_o    = nq_r;
  assign d_o     = d_r;
  assign ctl_o   = ctl_r;

endmodule

// ----- src/divs_post.sv -----
// Exit stage: restores the signs of quotient and remainder and zeroes both on a
// zero divisor. Depends on divs_pkg.
module divs_post
  import divs_pkg::*;
#(
  parameter int W = DIVS_WORD_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       valid_i,
  input  logic [W-1:0]               q_i,
  input  logic [W-1:0]               r_i,
  input  divs_ctl_t                  ctl_i,
  output logic                       valid_o,
  output logic [DIVS_FIELD_BITS-1:0] quotient_o,
  output logic [DIVS_FIELD_BITS-1:0] remainder_o,
  output logic                       dz_o
);

  logic                       valid_r;
  logic [DIVS_FIELD_BITS-1:0] q_r, rem_r;
  logic                       dz_r;
  logic [W-1:0]               q_s, r_s;

  always_comb begin
    q_s = ctl_i.neg_q ? W'(~q_i + 1'b1) : q_i;
    r_s = ctl_i.neg_r ? W'(~r_i + 1'b1) : r_i;
    if (ctl_i.dz) begin
      q_s = '0;
      r_s = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r   <= DIVS_FIELD_BITS'(q_s);
      rem_r <= DIVS_FIELD_BITS'(r_s);
      dz_r  <= ctl_i.dz;
    end
  end

  assign valid_o     = valid_r;
  assign quotient_o  = q_r;
  assign remainder_o = rem_r;
  assign dz_o        = dz_r;

endmodule

// ----- src/int64_divmod_signed_unsigned.sv -----
// Top level of the pipelined signed/unsigned divider: entry stage, WORD_BITS division
// steps, exit stage, then an output register with a skid entry.
// Depends on divs_pkg, divs_if, divs_pre, divs_step and divs_post.
//
//   Channel   Direction  Payload                                   Handshake
//   in_if     in         op, dividend, divisor                     valid/ready
//   out_if    out        quotient, remainder, div_by_zero          valid/ready
//
// One transaction is accepted per cycle while the skid entry is empty. A result passes
// the entry stage, which loads on the accepting edge, then one stage per quotient bit,
// the exit stage and the output register, where out_if.valid rises. The whole pipeline
// advances together and holds while the skid entry is full, so in_if.ready is a
// register. Reset clears all valid bits.
module int64_divmod_signed_unsigned
  import divs_pkg::*;
#(
  parameter int WORD_BITS = DIVS_WORD_BITS
) (
  input  logic   clk,
  input  logic   rst_n,
  divs_in_if.sink    in_if,
  divs_out_if.source out_if
);

  localparam int W = WORD_BITS;

  logic                       adv;
  logic                       st_valid [W+1];
  logic [W-1:0]               st_r     [W+1];
  logic [W-1:0]               st_nq    [W+1];
  logic [W-1:0]               st_d     [W+1];
  divs_ctl_t                  st_ctl   [W+1];

  logic                       p_valid;
  logic [DIVS_FIELD_BITS-1:0] p_q, p_rem;
  logic                       p_dz;

  logic                       out_v_r, out_v_nxt;
  logic [DIVS_FIELD_BITS-1:0] out_q_r, out_rem_r;
  logic                       out_dz_r;
  logic                       skid_v_r, skid_v_nxt;
  logic [DIVS_FIELD_BITS-1:0] skid_q_r, skid_rem_r;
  logic                       skid_dz_r;

  assign adv         = !skid_v_r;
  assign in_if.ready = adv;

  divs_pre #(.W(W)) u_pre (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .valid_i    (in_if.valid),
    .op_i       (in_if.op),
    .dividend_i (in_if.dividend),
    .divisor_i  (in_if.divisor),
    .valid_o    (st_valid[0]),
    .n_o        (st_nq[0]),
    .d_o        (st_d[0]),
    .ctl_o      (st_ctl[0])
  );

  assign st_r[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_step
    divs_step #(.W(W)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .valid_i (st_valid[k]),
      .r_i     (st_r[k]),
      .nq_i    (st_nq[k]),
      .d_i     (st_d[k]),
      .ctl_i   (st_ctl[k]),
      .valid_o (st_valid[k+1]),
      .r_o     (st_r[k+1]),
      .nq_o    (st_nq[k+1]),
      .d_o     (st_d[k+1]),
      .ctl_o   (st_ctl[k+1])
    );
  end

  divs_post #(.W(W)) u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .valid_i     (st_valid[W]),
    .q_i         (st_nq[W]),
    .r_i         (st_r[W]),
    .ctl_i       (st_ctl[W]),
    .valid_o     (p_valid),
    .quotient_o  (p_q),
    .remainder_o (p_rem),
    .dz_o        (p_dz)
  );

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (out_if.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = adv && p_valid;
      end
    end else if (adv && p_valid) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_if.ready || !out_v_r) begin
      if (skid_v_r) begin
        out_q_r   <= skid_q_r;
        out_rem_r <= skid_rem_r;
        out_dz_r  <= skid_dz_r;
      end else if (adv && p_valid) begin
        out_q_r   <= p_q;
        out_rem_r <= p_rem;
        out_dz_r  <= p_dz;
      end
    end else if (adv && p_valid) begin
      skid_q_r   <= p_q;
      skid_rem_r <= p_rem;
      skid_dz_r  <= p_dz;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.quotient    = out_q_r;
  assign out_if.remainder   = out_rem_r;
  assign out_if.div_by_zero = out_dz_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("Skid entry is full while the output register is empty.");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_if.ready |=> skid_v_r)
    else $error("Skid entry was dropped without an output transaction.");

  a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv && p_valid |=> p_valid)
    else $error("Exit stage lost its result during a stall.");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_dz_r |-> (out_q_r == '0) && (out_rem_r == '0))
    else $error("Zero divisor result carries a nonzero quotient or remainder.");

endmodule
